FILE: src/mss_pkg.sv
// Shared types and constants of the multi-slot stuck watchdog.
package mss_pkg;

    localparam int TIME_W = 48;
    localparam int TPS_W  = 20;
    localparam int SECS_W = 16;
    localparam int TAG_W  = 16;
    localparam int SLOT_W = 6;
    localparam int SPAN_W = TPS_W + SECS_W;

    localparam logic [TIME_W-1:0] TIME_MAX  = '1;
    localparam logic [TPS_W-1:0]  TPS_RESET = 20'd1000;

    typedef enum logic [2:0] {
        CMD_OPEN        = 3'd0,
        CMD_CLAIM       = 3'd1,
        CMD_CHECK_IN    = 3'd2,
        CMD_CHECK_OUT   = 3'd3,
        CMD_DELAY_ARM   = 3'd4,
        CMD_DELAY_CLEAR = 3'd5,
        CMD_TICK        = 3'd6,
        CMD_SCAN        = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_DELAY = 2'd1,
        CAUSE_SLOT  = 2'd2
    } t_cause;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_ADD,
        ST_SCAN_DLY,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic [SLOT_W-1:0] slot;
        logic [SECS_W-1:0] timeout_seconds;
        logic [TAG_W-1:0]  tag;
    } t_req;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] claimed_slot;
        logic              tripped;
        t_cause            trip_cause;
        logic [SLOT_W-1:0] trip_slot;
        logic [TAG_W-1:0]  trip_tag;
    } t_rsp;

endpackage

FILE: src/mss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/multi_slot_stuck_watchdog.sv
// Top level of the multi-slot stuck watchdog: command sequencer and timer datapath.
//
// Usage: software sends requests on the input channel (i_in_valid / o_in_stall,
// payload i_req). Every request yields exactly one response on the output
// channel (o_out_valid / i_out_stall, payload o_rsp). ticks_per_second is set
// through i_cfg_we / i_cfg_wdata while the block is idle.
// Path from accept to response: check-in and delay arm with a nonzero timeout
// pass through a multiply state and an add state; a scan with no trip latched
// checks the delay timer, then the claimed slots in order until one trips, and
// stops at once if the delay timer trips or no slot is claimed; everything else,
// rejected ones included, goes from decode to the response. One request is
// worked on at a time: the next one can be accepted in the cycle after the response
// is loaded. Scan speed is set by the single shared 48-bit adder/comparator and
// the one read port of the deadline/tag RAM: one slot per cycle after a read start.
// The response sits in an output register, so a stalled receiver holds only
// that register; a new request is taken meanwhile and waits in its final
// state until the register frees up.
// Reset clears time, the open flag, trip latch, claims, armed bits and the
// delay timer; ticks_per_second returns to 1000. The deadline/tag RAM is not
// cleared: an entry is used only while its armed bit is set.
module multi_slot_stuck_watchdog #(
    parameter int SLOTS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [mss_pkg::TPS_W-1:0] i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  mss_pkg::t_req            i_req,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output mss_pkg::t_rsp            o_rsp
);
    import mss_pkg::*;

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot index width
    localparam int CW    = $clog2(SLOTS + 1);                // claim count width
    localparam int RAM_W = TIME_W + TAG_W;

    // control state
    t_state              r_state, n_state;
    logic [TPS_W-1:0]    r_tps;
    logic [TIME_W-1:0]   r_now;
    logic                r_opened;
    logic                r_trip;
    logic [CW-1:0]       r_claimed;
    logic [SLOTS-1:0]    r_armed;
    logic                r_dly_armed;
    logic [TIME_W-1:0]   r_dly_dl;
    logic                r_out_valid;

    // payload
    t_req                r_req;
    t_rsp                r_res;
    t_rsp                r_out;
    logic [SPAN_W-1:0]   r_span;
    logic [SW-1:0]       r_idx;

    // shared adder / comparator
    logic [TIME_W-1:0]   u_a, u_b;
    logic                u_sub;
    logic [TIME_W:0]     w_sum;
    logic                w_carry;
    logic [TIME_W-1:0]   w_add_res;
    logic                w_expired;

    // RAM port
    logic                ram_we;
    logic [SW-1:0]       ram_raddr;
    logic [RAM_W-1:0]    ram_wdata;
    logic [RAM_W-1:0]    ram_rdata;
    logic [TIME_W-1:0]   w_rd_dl;
    logic [TAG_W-1:0]    w_rd_tag;

    // decode helpers
    logic [SW-1:0]       w_slot_idx;
    logic                w_slot_ok;
    logic                w_full;
    logic                w_last;
    logic                w_secs_zero;
    logic                w_dly_hit;
    logic                w_slot_hit;
    logic                w_out_free;

    // Add: a + b, saturating on carry. Compare: a + ~b + 1, carry clear
    // means b > a, i.e. time is past the deadline.
    assign w_sum     = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + (TIME_W+1)'(u_sub);
    assign w_carry   = w_sum[TIME_W];
    assign w_add_res = w_carry ? TIME_MAX : w_sum[TIME_W-1:0];
    assign w_expired = !w_carry;

    assign w_rd_dl   = ram_rdata[RAM_W-1 -: TIME_W];
    assign w_rd_tag  = ram_rdata[TAG_W-1:0];
    assign ram_wdata = {w_add_res, r_req.tag};

    assign w_slot_idx  = SW'(r_req.slot);
    assign w_slot_ok   = ((CW+SLOT_W)'(r_req.slot) < (CW+SLOT_W)'(r_claimed));
    assign w_full      = (r_claimed == CW'(SLOTS));
    assign w_last      = ((CW'(r_idx) + CW'(1)) == r_claimed);
    assign w_secs_zero = (r_req.timeout_seconds == '0);
    assign w_dly_hit   = r_dly_armed && w_expired;
    assign w_slot_hit  = r_armed[r_idx] && w_expired;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    mss_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (w_slot_idx),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_DONE;
                if (r_opened) begin
                    case (r_req.cmd)
                        CMD_CHECK_IN: begin
                            if (w_slot_ok && !w_secs_zero) begin
                                n_state = ST_MUL;
                            end
                        end
                        CMD_DELAY_ARM: begin
                            if (!w_secs_zero) begin
                                n_state = ST_MUL;
                            end
                        end
                        CMD_SCAN: begin
                            if (!r_trip) begin
                                n_state = ST_SCAN_DLY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL:      n_state = ST_ADD;
            ST_ADD:      n_state = ST_DONE;
            ST_SCAN_DLY: begin
                if (w_dly_hit || (r_claimed == '0)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:  n_state = ST_SCAN_CMP;
            ST_SCAN_CMP: begin
                if (w_slot_hit || w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake, RAM port, shared unit operands
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        ram_we     = 1'b0;
        ram_raddr  = r_idx;
        u_a        = r_now;
        u_b        = '0;
        u_sub      = 1'b0;
        case (r_state)
            ST_DECODE: begin
                u_b = TIME_W'(1);          // tick increment
            end
            ST_ADD: begin
                u_b    = TIME_W'(r_span);
                ram_we = (r_req.cmd == CMD_CHECK_IN);
            end
            ST_SCAN_DLY: begin
                u_a   = r_dly_dl;
                u_b   = r_now;
                u_sub = 1'b1;
            end
            ST_SCAN_CMP: begin
                u_a       = w_rd_dl;
                u_b       = r_now;
                u_sub     = 1'b1;
                ram_raddr = r_idx + SW'(1);  // prefetch the next slot
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tps       <= TPS_RESET;
            r_now       <= '0;
            r_opened    <= 1'b0;
            r_trip      <= 1'b0;
            r_claimed   <= '0;
            r_armed     <= '0;
            r_dly_armed <= 1'b0;
            r_dly_dl    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tps <= i_cfg_wdata;
            end
            case (r_state)
                ST_DECODE: begin
                    case (r_req.cmd)
                        CMD_TICK: r_now <= w_add_res;
                        CMD_OPEN: begin
                            r_opened    <= 1'b1;
                            r_trip      <= 1'b0;
                            r_claimed   <= '0;
                            r_armed     <= '0;
                            r_dly_armed <= 1'b0;
                            r_dly_dl    <= '0;
                        end
                        CMD_CLAIM: begin
                            if (r_opened && !w_full) begin
                                r_claimed <= r_claimed + CW'(1);
                            end
                        end
                        CMD_CHECK_IN, CMD_CHECK_OUT: begin
                            if (r_opened && w_slot_ok &&
                                ((r_req.cmd == CMD_CHECK_OUT) || w_secs_zero)) begin
                                r_armed[w_slot_idx] <= 1'b0;
                            end
                        end
                        CMD_DELAY_ARM: begin
                            if (r_opened && w_secs_zero) begin
                                r_dly_armed <= 1'b0;
                                r_dly_dl    <= '0;
                            end
                        end
                        CMD_DELAY_CLEAR: begin
                            if (r_opened) begin
                                r_dly_armed <= 1'b0;
                                r_dly_dl    <= '0;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_ADD: begin
                    if (r_req.cmd == CMD_CHECK_IN) begin
                        r_armed[w_slot_idx] <= 1'b1;
                    end else begin
                        r_dly_dl    <= w_add_res;
                        r_dly_armed <= 1'b1;
                    end
                end
                ST_SCAN_DLY: begin
                    if (w_dly_hit) begin
                        r_trip <= 1'b1;
                    end
                end
                ST_SCAN_CMP: begin
                    if (w_slot_hit) begin
                        r_trip <= 1'b1;
                    end
                end
                default: ;
            endcase
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_req <= i_req;
                    r_res <= '0;
                end
            end
            ST_DECODE: begin
                if ((r_req.cmd != CMD_TICK) && (r_req.cmd != CMD_OPEN)) begin
                    if (!r_opened) begin
                        r_res.status <= 1'b1;
                    end else if (r_req.cmd == CMD_CLAIM) begin
                        if (w_full) begin
                            r_res.status <= 1'b1;
                        end else begin
                            r_res.claimed_slot <= SLOT_W'(r_claimed);
                        end
                    end else if (r_req.cmd inside {CMD_CHECK_IN, CMD_CHECK_OUT}) begin
                        if (!w_slot_ok) begin
                            r_res.status <= 1'b1;
                        end
                    end
                end
            end
            ST_MUL: begin
                r_span <= SPAN_W'(r_tps) * SPAN_W'(r_req.timeout_seconds);
            end
            ST_SCAN_DLY: begin
                r_idx <= '0;
                if (w_dly_hit) begin
                    r_res.tripped    <= 1'b1;
                    r_res.trip_cause <= CAUSE_DELAY;
                end
            end
            ST_SCAN_CMP: begin
                if (w_slot_hit) begin
                    r_res.tripped    <= 1'b1;
                    r_res.trip_cause <= CAUSE_SLOT;
                    r_res.trip_slot  <= SLOT_W'(r_idx);
                    r_res.trip_tag   <= w_rd_tag;
                end else begin
                    r_idx <= r_idx + SW'(1);
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_out <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

FILE: src/mss_chk.sv
// Port-level checker for the multi-slot stuck watchdog and its bind.
module mss_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cfg_we,
    input logic [mss_pkg::TPS_W-1:0] i_cfg_wdata,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input mss_pkg::t_req             i_req,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input mss_pkg::t_rsp             o_rsp
);
    import mss_pkg::*;

    // one request at a time: an accept closes the input side
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous one still in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_rsp)))
        else $error("stalled response changed");

    a_trip_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_rsp.tripped) |->
        ((o_rsp.trip_cause == CAUSE_NONE) && (o_rsp.trip_slot == '0) &&
         (o_rsp.trip_tag == '0)))
        else $error("trip fields set without a trip");

    a_trip_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rsp.tripped) |->
        ((o_rsp.status == 1'b0) &&
         ((o_rsp.trip_cause == CAUSE_DELAY) || (o_rsp.trip_cause == CAUSE_SLOT))))
        else $error("trip reported without a valid cause");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rsp.status) |->
        ((o_rsp.claimed_slot == '0) && !o_rsp.tripped))
        else $error("rejected request carries result data");

endmodule

bind multi_slot_stuck_watchdog mss_chk u_mss_chk (.*);

FILE: sim/multi_slot_stuck_watchdog_tb.sv
// Self-checking testbench for multi_slot_stuck_watchdog: randomized request sessions vs. a predictor.
module multi_slot_stuck_watchdog_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mss_pkg::*;

    localparam int NSLOTS     = 64;
    localparam int SETTLE     = 8;     // every request answers, so a short settle is enough
    localparam int TAIL       = 100;   // longer than a full 64-slot scan
    localparam int HANG_LIMIT = 5000;  // cycles with no handshake on either side
    localparam int HOLD_LEN   = 400;   // one long receiver hold-off
    localparam int HOLD_AT    = 300;   // responses seen before that hold-off starts

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [TPS_W-1:0]  i_cfg_wdata = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_req              i_req = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_rsp              o_rsp;

    multi_slot_stuck_watchdog #(.SLOTS(NSLOTS)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req       (i_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rsp       (o_rsp)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the watchdog.
    // ------------------------------------------------------------------
    logic [TPS_W-1:0]  tps_now;
    bit                wd_open;
    bit                trip_held;
    logic [TIME_W-1:0] clock_ticks;
    int unsigned       claim_count;
    bit                armed [NSLOTS];
    logic [TIME_W-1:0] deadline [NSLOTS];
    logic [TAG_W-1:0]  tag_mem [NSLOTS];
    bit                dly_armed;
    logic [TIME_W-1:0] dly_deadline;

    t_req req_backlog[$];   // requests waiting for the driver
    t_rsp rsp_due[$];       // predicted responses, oldest first

    int  mismatches = 0;
    int  queued_items = 0;
    bit  quiet = 1'b0;      // when set, neither side idles

    // now + tps * secs, clamped at the top of the time range
    function automatic logic [TIME_W-1:0] due_time(logic [SECS_W-1:0] secs);
        logic [SPAN_W-1:0] span;
        logic [TIME_W:0]   sum;
        span = tps_now * secs;
        sum  = {1'b0, clock_ticks} + span;
        return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    // Applies one request to the predictor state and returns its response.
    function automatic t_rsp next_watchdog_rsp(t_req r);
        t_rsp rsp;
        rsp = '0;
        if (r.cmd == CMD_TICK) begin
            if (clock_ticks != TIME_MAX) clock_ticks = clock_ticks + 1'b1;
        end else if (r.cmd == CMD_OPEN) begin
            wd_open      = 1'b1;
            trip_held    = 1'b0;
            claim_count  = 0;
            armed        = '{default: 1'b0};
            dly_armed    = 1'b0;
            dly_deadline = '0;
        end else if (!wd_open) begin
            rsp.status = 1'b1;
        end else begin
            case (r.cmd)
                CMD_CLAIM: begin
                    if (claim_count >= NSLOTS) begin
                        rsp.status = 1'b1;
                    end else begin
                        rsp.claimed_slot = 6'(claim_count);
                        claim_count++;
                    end
                end
                CMD_CHECK_IN, CMD_CHECK_OUT: begin
                    if (r.slot >= claim_count) begin
                        rsp.status = 1'b1;
                    end else if (r.cmd == CMD_CHECK_OUT) begin
                        armed[r.slot] = 1'b0;
                    end else begin
                        tag_mem[r.slot] = r.tag;
                        if (r.timeout_seconds == '0) begin
                            armed[r.slot] = 1'b0;
                        end else begin
                            deadline[r.slot] = due_time(r.timeout_seconds);
                            armed[r.slot]    = 1'b1;
                        end
                    end
                end
                CMD_DELAY_ARM: begin
                    if (r.timeout_seconds == '0) begin
                        dly_armed    = 1'b0;
                        dly_deadline = '0;
                    end else begin
                        dly_deadline = due_time(r.timeout_seconds);
                        dly_armed    = 1'b1;
                    end
                end
                CMD_DELAY_CLEAR: begin
                    dly_armed    = 1'b0;
                    dly_deadline = '0;
                end
                default: begin
                    // scan: delay timer first, then claimed slots in order
                    if (!trip_held) begin
                        if (dly_armed && clock_ticks > dly_deadline) begin
                            rsp.tripped    = 1'b1;
                            rsp.trip_cause = CAUSE_DELAY;
                        end else begin
                            for (int i = 0; i < claim_count; i++) begin
                                if (armed[i] && clock_ticks > deadline[i]) begin
                                    rsp.tripped    = 1'b1;
                                    rsp.trip_cause = CAUSE_SLOT;
                                    rsp.trip_slot  = 6'(i);
                                    rsp.trip_tag   = tag_mem[i];
                                    break;
                                end
                            end
                        end
                        if (rsp.tripped) trip_held = 1'b1;
                    end
                end
            endcase
        end
        return rsp;
    endfunction

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_req(t_cmd c, int slot, int secs, int tag);
        t_req r;
        r.cmd             = c;
        r.slot            = SLOT_W'(slot);
        r.timeout_seconds = SECS_W'(secs);
        r.tag             = TAG_W'(tag);
        req_backlog.push_back(r);
        queued_items++;
    endtask

    // Mostly well-formed: open, a run of claims, then traffic on the claimed
    // slots with short tick bursts so deadlines actually pass. Some noise too.
    task automatic queue_session();
        int n_claim;
        int body;
        int pick;
        int secs;
        int slot;
        n_claim = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 6);
        body    = $urandom_range(10, 60);
        if ($urandom_range(0, 99) < 85) queue_req(CMD_OPEN, $urandom_range(0, 63),
                                                  $urandom, $urandom);
        repeat (n_claim) queue_req(CMD_CLAIM, $urandom_range(0, 63), $urandom, $urandom);
        repeat (body) begin
            pick = $urandom_range(0, 99);
            secs = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
            slot = ($urandom_range(0, 99) < 85) ? $urandom_range(0, (n_claim > NSLOTS ?
                   NSLOTS : n_claim) - 1) : $urandom_range(0, 63);
            if (pick < 25)
                queue_req(CMD_CHECK_IN, slot, secs, $urandom);
            else if (pick < 33)
                queue_req(CMD_CHECK_OUT, slot, $urandom, $urandom);
            else if (pick < 39)
                queue_req(CMD_DELAY_ARM, $urandom_range(0, 63), secs, $urandom);
            else if (pick < 43)
                queue_req(CMD_DELAY_CLEAR, $urandom_range(0, 63), $urandom, $urandom);
            else if (pick < 78)
                repeat ($urandom_range(1, 5))
                    queue_req(CMD_TICK, $urandom_range(0, 63), $urandom, $urandom);
            else if (pick < 93)
                queue_req(CMD_SCAN, $urandom_range(0, 63), $urandom, $urandom);
            else if (pick < 95)
                queue_req(CMD_CLAIM, $urandom_range(0, 63), $urandom, $urandom);
            else
                queue_req(t_cmd'($urandom_range(0, 7)), $urandom_range(0, 63),
                          $urandom, $urandom);
        end
    endtask

    // Block is idle once the backlog is sent and every response came back.
    task automatic wait_drained();
        while (req_backlog.size() != 0 || i_in_valid || rsp_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Request driver. The predictor runs at the accepting edge.
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) rsp_due.push_back(next_watchdog_rsp(i_req));
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0 || req_backlog.size() == 0) begin
                    i_in_valid <= 1'b0;
                    if (gap_left != 0) gap_left <= gap_left - 1;
                end else begin
                    i_req      <= req_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    gap_left   <= idle_len();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor and receiver stall.
    // ------------------------------------------------------------------
    int rsp_seen   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (rsp_due.size() == 0) begin
                    $error("response with nothing outstanding: %h", o_rsp);
                    mismatches++;
                end else begin
                    want = rsp_due.pop_front();
                    check_field("status", want.status, o_rsp.status);
                    check_field("claimed_slot", want.claimed_slot, o_rsp.claimed_slot);
                    check_field("tripped", want.tripped, o_rsp.tripped);
                    check_field("trip_cause", want.trip_cause, o_rsp.trip_cause);
                    check_field("trip_slot", want.trip_slot, o_rsp.trip_slot);
                    check_field("trip_tag", want.trip_tag, o_rsp.trip_tag);
                end
                rsp_seen++;
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
            end else if (stall_left != 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                stall_left = idle_len();
            end
        end
    end

    // One long hold-off so the block backs up into its input.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && rsp_seen >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // Hang detector: no handshake on either side for too long.
    int stuck_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= HANG_LIMIT) begin
                $display("multi_slot_stuck_watchdog_tb: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed checks, then random phases at several rates.
    // ------------------------------------------------------------------
    int tps_plan[] = '{0, 1, 2, 1000000, 3, 1, 1000, 0, 2};

    initial begin
        int target;
        tps_now      = TPS_RESET;
        wd_open      = 1'b0;
        trip_held    = 1'b0;
        clock_ticks  = '0;
        claim_count  = 0;
        armed        = '{default: 1'b0};
        deadline     = '{default: '0};
        tag_mem      = '{default: '0};
        dly_armed    = 1'b0;
        dly_deadline = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Everything but tick and open is refused before the first open.
        queue_req(CMD_CLAIM, 0, 0, 0);
        queue_req(CMD_CHECK_IN, 0, 5, 16'hFFFF);
        queue_req(CMD_CHECK_OUT, 0, 0, 0);
        queue_req(CMD_DELAY_ARM, 0, 1, 0);
        queue_req(CMD_DELAY_CLEAR, 0, 0, 0);
        queue_req(CMD_SCAN, 0, 0, 0);
        queue_req(CMD_TICK, 63, 16'hFFFF, 16'hFFFF);
        queue_req(CMD_OPEN, 0, 0, 0);
        queue_req(CMD_CLAIM, 0, 0, 0);
        queue_req(CMD_CLAIM, 0, 0, 0);
        // unclaimed slot indexes
        queue_req(CMD_CHECK_IN, 2, 1, 16'h1234);
        queue_req(CMD_CHECK_OUT, 63, 0, 0);
        // zero timeout keeps the slot disarmed; largest timeout arms it
        queue_req(CMD_CHECK_IN, 0, 0, 16'hFFFF);
        queue_req(CMD_CHECK_IN, 1, 16'hFFFF, 0);
        queue_req(CMD_CHECK_OUT, 1, 0, 0);
        queue_req(CMD_DELAY_ARM, 0, 16'hFFFF, 0);
        queue_req(CMD_DELAY_ARM, 0, 0, 0);
        queue_req(CMD_DELAY_CLEAR, 0, 0, 0);
        queue_req(CMD_TICK, 0, 0, 0);
        queue_req(CMD_SCAN, 0, 0, 0);
        target = queued_items + 100;
        while (queued_items < target) queue_session();
        wait_drained();

        foreach (tps_plan[p]) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= TPS_W'(tps_plan[p]);
            tps_now      = TPS_W'(tps_plan[p]);
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;
            quiet        = (p == 4);
            if (p == 0) begin
                // Zero rate: deadline equals now, expires after one tick.
                queue_req(CMD_OPEN, 0, 0, 0);
                queue_req(CMD_CLAIM, 0, 0, 0);
                queue_req(CMD_CHECK_IN, 0, 1, 16'hBEEF);
                queue_req(CMD_SCAN, 0, 0, 0);
                queue_req(CMD_TICK, 0, 0, 0);
                queue_req(CMD_SCAN, 0, 0, 0);
                // trip is latched: later scans report nothing
                queue_req(CMD_SCAN, 0, 0, 0);
                queue_req(CMD_DELAY_ARM, 0, 3, 0);
                queue_req(CMD_TICK, 0, 0, 0);
                queue_req(CMD_SCAN, 0, 0, 0);
                // open clears the latch; delay timer has priority
                queue_req(CMD_OPEN, 0, 0, 0);
                queue_req(CMD_CLAIM, 0, 0, 0);
                queue_req(CMD_CHECK_IN, 0, 1, 16'h5A5A);
                queue_req(CMD_DELAY_ARM, 0, 1, 0);
                queue_req(CMD_TICK, 0, 0, 0);
                queue_req(CMD_SCAN, 0, 0, 0);
            end
            target = queued_items + 120;
            while (queued_items < target) queue_session();
            wait_drained();
        end
        quiet = 1'b0;

        repeat (TAIL) @(posedge i_clk);
        if (rsp_due.size() != 0) begin
            $error("%0d responses never arrived", rsp_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("multi_slot_stuck_watchdog_tb: done, clean");
        else
            $display("multi_slot_stuck_watchdog_tb: done, errors");
        $finish;
    end

endmodule
